@@ design/sdiff_pkg.sv @@
// Shared types and constants of the smoothed slope differentiator.
`default_nettype none
package sdiff_pkg;

	localparam int RATE_BITS  = 18;
	localparam int RATE_RESET = 48000;

	typedef enum logic [0:0] {
		CFG_SAMPLE_RATE   = 1'b0,
		CFG_SMOOTH_WEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		CMD_SAMPLE = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		MUL_RAW,
		MUL_LO,
		MUL_HI
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MRAW,
		ST_RAW,
		ST_MAG,
		ST_MLO,
		ST_MHI,
		ST_STEP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic     clear;
		logic     ld_diff;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_raw;
		logic     ld_mag;
		logic     ld_lo;
		logic     ld_step;
		logic     ld_out;
	} ctrl_t;

endpackage
`default_nettype wire

@@ design/sdiff_mul.sv @@
// Shared unsigned multiplier with registered product.
`default_nettype none
module sdiff_mul #(
	parameter int AW = 25,
	parameter int BW = 18
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [AW-1:0]      a,
	input  wire logic [BW-1:0]      b,
	output logic      [AW+BW-1:0]   p_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= (AW+BW)'(a) * (AW+BW)'(b);
		end
	end

endmodule
`default_nettype wire

@@ design/sdiff_seq.sv @@
// Sequencer that steps one item through the shared multiplier.
`default_nettype none
module sdiff_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           cmd,
	input  wire logic           out_free,
	output logic                in_stall,
	output sdiff_pkg::ctrl_t    ctrl
);
	import sdiff_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctrl         = '0;
		ctrl.mul_sel = MUL_RAW;
		in_stall     = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_CLEAR) begin
						ctrl.clear = 1'b1;
					end else begin
						ctrl.ld_diff = 1'b1;
						state_d      = ST_MRAW;
					end
				end
			end
			ST_MRAW: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_RAW;
				state_d      = ST_RAW;
			end
			ST_RAW: begin
				ctrl.ld_raw = 1'b1;
				state_d     = ST_MAG;
			end
			ST_MAG: begin
				ctrl.ld_mag = 1'b1;
				state_d     = ST_MLO;
			end
			ST_MLO: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_LO;
				state_d      = ST_MHI;
			end
			ST_MHI: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_HI;
				ctrl.ld_lo   = 1'b1;
				state_d      = ST_STEP;
			end
			ST_STEP: begin
				ctrl.ld_step = 1'b1;
				state_d      = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					ctrl.ld_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/smoothed_slope_differentiator.sv @@
// Top level of the smoothed slope differentiator: registers, datapath, output stage.
`default_nettype none
// Takes signed audio samples and returns their smoothed rate of change per second.
// A sample item runs through one shared multiplier three times (difference times
// rate, then low and high halves of the slope error times the weight), so the
// block stalls further items until a sample item has passed all its states;
// a clear item is taken while idle and gives no result. The output register lets
// the next item enter while a result still waits.
module smoothed_slope_differentiator #(
	parameter int SAMPLE_BITS = 24,
	parameter int SLOPE_BITS  = 48,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 cmd,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [SLOPE_BITS-1:0]              slope,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire sdiff_pkg::cfg_reg_t                  cfg_index,
	input  wire logic [((sdiff_pkg::RATE_BITS > WEIGHT_BITS + 1) ?
		sdiff_pkg::RATE_BITS : WEIGHT_BITS + 1)-1:0] cfg_data
);
	import sdiff_pkg::*;

	localparam int WREG_W = WEIGHT_BITS + 1;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int RAW_W  = DIFF_W + RATE_BITS;
	localparam int MW     = (RAW_W > SLOPE_BITS) ? RAW_W : SLOPE_BITS;
	localparam int CW     = (MW + 1) / 2;
	localparam int AW     = (DIFF_W > CW) ? DIFF_W : CW;
	localparam int BW     = (RATE_BITS > WREG_W) ? RATE_BITS : WREG_W;
	localparam int PW     = AW + BW;
	localparam int SW     = PW + CW + 1;
	localparam int CURW   = MW + 2;

	localparam logic [WREG_W-1:0] W_ONE = WREG_W'(1) << WEIGHT_BITS;
	localparam logic [SW-1:0]     HALF  = SW'(1) << (WEIGHT_BITS - 1);
	localparam logic signed [CURW-1:0] BOUND =
		{{(CURW - SLOPE_BITS + 1){1'b0}}, {(SLOPE_BITS - 1){1'b1}}};

	ctrl_t ctrl;
	logic  out_free;

	logic [RATE_BITS-1:0] rate_q;
	logic [WREG_W-1:0]    wreg_q;
	logic [WREG_W-1:0]    w_sat;

	logic                          primed_q;
	logic signed [SAMPLE_BITS-1:0] last_q;
	logic signed [SLOPE_BITS-1:0]  smooth_q;

	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic [DIFF_W-1:0]             diff_mag_q;
	logic                          diff_neg_q;
	logic signed [RAW_W-1:0]       raw_q;
	logic [MW-1:0]                 mag_q;
	logic                          rise_q;
	logic [PW-1:0]                 plo_q;
	logic [MW-1:0]                 step_q;
	logic                          out_valid_q;
	logic signed [SLOPE_BITS-1:0]  slope_q;

	logic signed [SAMPLE_BITS-1:0] last_eff;
	logic signed [DIFF_W-1:0]      diff;
	logic [AW-1:0]                 mul_a;
	logic [BW-1:0]                 mul_b;
	logic [PW-1:0]                 p_q;
	logic signed [RAW_W-1:0]       raw_pos;
	logic signed [MW:0]            raw_x;
	logic signed [MW:0]            prev_x;
	logic signed [MW:0]            d_up;
	logic signed [MW:0]            d_dn;
	logic [SW-1:0]                 step_sum;
	logic signed [CURW-1:0]        prev_c;
	logic signed [CURW-1:0]        step_c;
	logic signed [CURW-1:0]        cur;
	logic signed [CURW-1:0]        cur_sat;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign slope     = slope_q;

	sdiff_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.out_free (out_free),
		.in_stall (in_stall),
		.ctrl     (ctrl)
	);

	sdiff_mul #(
		.AW (AW),
		.BW (BW)
	) u_mul (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_BITS'(RATE_RESET);
			wreg_q <= W_ONE;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SAMPLE_RATE) begin
				rate_q <= cfg_data[RATE_BITS-1:0];
			end
			if (cfg_index == CFG_SMOOTH_WEIGHT) begin
				wreg_q <= cfg_data[WREG_W-1:0];
			end
		end
	end

	assign w_sat = (wreg_q > W_ONE) ? W_ONE : wreg_q;

	// sample difference
	assign last_eff = primed_q ? last_q : sample;
	assign diff     = DIFF_W'(sample) - DIFF_W'(last_eff);

	always_comb begin
		unique case (ctrl.mul_sel)
			MUL_RAW: begin
				mul_a = AW'(diff_mag_q);
				mul_b = BW'(rate_q);
			end
			MUL_LO: begin
				mul_a = AW'(mag_q[CW-1:0]);
				mul_b = BW'(w_sat);
			end
			MUL_HI: begin
				mul_a = AW'(mag_q[MW-1:CW]);
				mul_b = BW'(w_sat);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign raw_pos  = $signed(p_q[RAW_W-1:0]);
	assign raw_x    = (MW+1)'(raw_q);
	assign prev_x   = (MW+1)'(smooth_q);
	assign d_up     = raw_x - prev_x;
	assign d_dn     = prev_x - raw_x;
	assign step_sum = (SW'(p_q) << CW) + SW'(plo_q) + HALF;

	assign prev_c = CURW'(smooth_q);
	assign step_c = $signed(CURW'(step_q));
	assign cur    = rise_q ? (prev_c + step_c) : (prev_c - step_c);

	always_comb begin
		priority if (cur > BOUND) begin
			cur_sat = BOUND;
		end else if (cur < -BOUND) begin
			cur_sat = -BOUND;
		end else begin
			cur_sat = cur;
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		if (ctrl.ld_diff) begin
			samp_q     <= sample;
			diff_neg_q <= diff[DIFF_W-1];
			diff_mag_q <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		end
		if (ctrl.ld_raw) begin
			raw_q <= diff_neg_q ? -raw_pos : raw_pos;
		end
		if (ctrl.ld_mag) begin
			rise_q <= (raw_x >= prev_x);
			mag_q  <= (raw_x >= prev_x) ? d_up[MW-1:0] : d_dn[MW-1:0];
		end
		if (ctrl.ld_lo) begin
			plo_q <= p_q;
		end
		if (ctrl.ld_step) begin
			step_q <= step_sum[WEIGHT_BITS +: MW];
		end
		if (ctrl.ld_out) begin
			slope_q <= cur_sat[SLOPE_BITS-1:0];
		end
	end

	// history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			last_q   <= '0;
			smooth_q <= '0;
		end else if (ctrl.clear) begin
			primed_q <= 1'b0;
			last_q   <= '0;
			smooth_q <= '0;
		end else if (ctrl.ld_out) begin
			primed_q <= 1'b1;
			last_q   <= samp_q;
			smooth_q <= cur_sat[SLOPE_BITS-1:0];
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the smoothed slope differentiator: directed, corner and random tests.
`default_nettype none
module tb;
	import sdiff_pkg::*;

	localparam int SAMPLE_W = 24;
	localparam int SLOPE_W  = 48;
	localparam int CFG_W    = 18;
	localparam int IDLE_PCT = 24;
	localparam int SETTLE   = 16;
	localparam int LIMIT    = 400000;
	localparam longint SLOPE_MAX = (64'sd1 <<< (SLOPE_W - 1)) - 1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_HI = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_LO = 24'h800000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cmd_t cmd = CMD_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SLOPE_W-1:0] slope;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = CFG_SAMPLE_RATE;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor state
	longint unsigned rate_now;
	longint unsigned weight_now;
	bit have_prev;
	longint prev_sample;
	longint last_slope;
	logic [SLOPE_W-1:0] slope_q[$];

	bit steady = 1'b0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned slopes_checked = 0;
	int unsigned samples_sent = 0;
	int unsigned clears_sent = 0;
	int unsigned reg_writes = 0;
	logic [SLOPE_W-1:0] want_slope;

	smoothed_slope_differentiator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slope(slope),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d slopes pending", cycles, slope_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (slope_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected slope %0d at cycle %0d", slope, cycles);
			end else begin
				want_slope = slope_q.pop_front();
				slopes_checked++;
				if (slope !== want_slope) begin
					mismatches++;
					if (mismatches <= 10)
						$display("slope mismatch at cycle %0d: expected %0d, got %0d",
							cycles, $signed(want_slope), slope);
				end
			end
		end
	end

	function automatic void reset_predictor();
		rate_now = RATE_RESET;
		weight_now = 65536;
		have_prev = 1'b0;
		prev_sample = 0;
		last_slope = 0;
	endfunction

	function automatic void predict_slope(input cmd_t c, input logic signed [SAMPLE_W-1:0] s);
		longint cur_sample;
		longint raw;
		longint cur;
		longint unsigned w;
		longint unsigned mag;
		longint unsigned step;
		bit rising;
		if (c == CMD_CLEAR) begin
			have_prev = 1'b0;
			prev_sample = 0;
			last_slope = 0;
			return;
		end
		cur_sample = longint'(s);
		if (!have_prev) begin
			prev_sample = cur_sample;
			have_prev = 1'b1;
		end
		raw = (cur_sample - prev_sample) * longint'(rate_now);
		w = (weight_now > 65536) ? 65536 : weight_now;
		rising = raw >= last_slope;
		mag = rising ? raw - last_slope : last_slope - raw;
		// magnitude split in halves so the weight product cannot overflow
		step = (mag >> 16) * w + (((mag & 64'hFFFF) * w + 64'h8000) >> 16);
		cur = rising ? last_slope + longint'(step) : last_slope - longint'(step);
		if (cur > SLOPE_MAX)
			cur = SLOPE_MAX;
		else if (cur < -SLOPE_MAX)
			cur = -SLOPE_MAX;
		last_slope = cur;
		prev_sample = cur_sample;
		slope_q.push_back(cur[SLOPE_W-1:0]);
	endfunction

	task automatic send_item(input cmd_t c, input logic [SAMPLE_W-1:0] s);
		while (!steady && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sample <= s;
		do
			@(posedge clk);
		while (in_stall);
		predict_slope(c, s);
		if (c == CMD_CLEAR)
			clears_sent++;
		else
			samples_sent++;
	endtask

	task automatic send_samples(input logic [SAMPLE_W-1:0] vals[$]);
		foreach (vals[i])
			send_item(CMD_SAMPLE, vals[i]);
	endtask

	// drain outstanding slopes, then give a trailing clear time to finish
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (slope_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] weight);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SAMPLE_RATE;
		cfg_data <= rate;
		do
			@(posedge clk);
		while (!cfg_ready);
		rate_now = 64'(rate);
		cfg_index <= CFG_SMOOTH_WEIGHT;
		cfg_data <= weight;
		do
			@(posedge clk);
		while (!cfg_ready);
		weight_now = 64'(weight[16:0]);
		cfg_valid <= 1'b0;
		reg_writes += 2;
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] last);
		int unsigned mode;
		mode = $urandom_range(99);
		if (mode < 45)
			return last + SAMPLE_W'($urandom_range(2048)) - 24'd1024;
		else if (mode < 65)
			return last + SAMPLE_W'($urandom_range(65536)) - 24'd32768;
		else if (mode < 90)
			return SAMPLE_W'($urandom());
		else if (mode < 95)
			return SAMPLE_HI;
		else
			return SAMPLE_LO;
	endfunction

	function automatic logic [CFG_W-1:0] pick_rate();
		case ($urandom_range(7))
			0: return 18'd0;
			1: return 18'd1;
			2: return 18'd44100;
			3: return 18'd48000;
			4: return 18'd192000;
			5: return 18'h3FFFF;
			default: return CFG_W'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_weight();
		logic [CFG_W-1:0] w;
		case ($urandom_range(7))
			0: w = 18'd0;
			1: w = 18'd1;
			2: w = 18'd65535;
			3: w = 18'd65536;
			4: w = 18'h1FFFF;
			5: w = CFG_W'($urandom_range(4000, 1));
			default: w = CFG_W'($urandom_range(131071));
		endcase
		w[17] = 1'($urandom_range(1));
		return w;
	endfunction

	task automatic test_reset_defaults();
		send_samples('{24'd1000, SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, 24'd0, 24'hFFFFFF});
		send_item(CMD_CLEAR, 24'h5A5A5A);
		send_samples('{24'h123456, 24'h123457});
		send_item(CMD_CLEAR, 24'd0);
		send_item(CMD_CLEAR, SAMPLE_LO);
		send_samples('{SAMPLE_LO});
	endtask

	task automatic test_config_corners();
		set_config(18'd0, 18'd65536);
		send_samples('{24'd100, 24'hFFEC78});
		set_config(18'h3FFFF, 18'd65536);
		send_samples('{SAMPLE_HI, SAMPLE_LO, SAMPLE_HI});
		set_config(18'h3FFFF, 18'd0);
		send_samples('{SAMPLE_LO, SAMPLE_HI});
		set_config(18'd1, 18'd1);
		send_samples('{24'd0, SAMPLE_HI, 24'd1});
		set_config(18'd192000, 18'h3FFFF);
		send_samples('{24'd0, SAMPLE_LO});
		set_config(18'd44100, 18'd178);
		send_samples('{24'd0, SAMPLE_HI, SAMPLE_HI, 24'd0});
	endtask

	task automatic test_random_streams();
		logic [SAMPLE_W-1:0] last;
		last = '0;
		repeat (5) begin
			set_config(pick_rate(), pick_weight());
			repeat (104) begin
				if ($urandom_range(99) < 6) begin
					send_item(CMD_CLEAR, SAMPLE_W'($urandom()));
				end else begin
					last = pick_sample(last);
					send_item(CMD_SAMPLE, last);
				end
			end
		end
	endtask

	task automatic test_back_to_back();
		logic [SAMPLE_W-1:0] last;
		last = '0;
		set_config(18'd48000, 18'd2500);
		steady = 1'b1;
		repeat (80) begin
			if ($urandom_range(99) < 5) begin
				send_item(CMD_CLEAR, SAMPLE_W'($urandom()));
			end else begin
				last = pick_sample(last);
				send_item(CMD_SAMPLE, last);
			end
		end
		wait_quiet();
		steady = 1'b0;
	endtask

	initial begin
		reset_predictor();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_corners();
		test_random_streams();
		test_back_to_back();
		wait_quiet();
		$display("covered %0d samples, %0d clears, %0d register writes; %0d slopes checked",
			samples_sent, clears_sent, reg_writes, slopes_checked);
		$display("rate and weight corners, clears mid-stream, random and back-to-back flow");
		if (mismatches == 0 && slope_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d slopes never seen", mismatches, slope_q.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
